### rtl/core/irfd_pkg.sv
// Shared types and constants of the IR remote frame decoder.
`default_nettype none
package irfd_pkg;

   localparam int INTERVAL_W      = 18;
   localparam int ADDR_W          = 16;
   localparam int CMD_W           = 16;
   localparam int STATUS_W        = 2;
   localparam int FRAME_BITS      = 32;
   localparam int BIT_CNT_W       = 6;
   localparam int EDGES_PER_FRAME = 50;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 18;
   localparam int CLASS_DEPTH     = 4;
   localparam int RESULT_DEPTH    = 2;

   localparam logic [ADDR_W-1:0]     DEVICE_ADDRESS_RESET = 16'd0;
   localparam logic [INTERVAL_W-1:0] LEADER_THRESH_RESET  = 18'd8000;
   localparam logic [INTERVAL_W-1:0] ONE_THRESH_RESET     = 18'd1700;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEADER_THRESH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_THRESH     = 2'd2;

   // Frame status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_LEADER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FEW_BITS  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ADDR_MISS = 2'd3;

   // Classified edge handed from front to back
   typedef struct packed {
      logic above_leader;
      logic above_one;
      logic frame_last;
   } edge_class_type;

   // One decoded frame
   typedef struct packed {
      logic [STATUS_W-1:0] frame_status;
      logic [ADDR_W-1:0]   address_code;
      logic [CMD_W-1:0]    command_code;
   } frame_result_type;

endpackage
`default_nettype wire

### rtl/core/irfd_queue.sv
// Small first-in first-out word queue.
`default_nettype none
module irfd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("queue holds more words than its depth");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) || (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule
`default_nettype wire

### rtl/core/irfd_front.sv
// Front end: takes edge intervals, classifies them against the thresholds, counts frame edges.
`default_nettype none
module irfd_front #(
   parameter int EDGES_PER_FRAME = irfd_pkg::EDGES_PER_FRAME
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   input  wire logic [irfd_pkg::INTERVAL_W-1:0]  req_interval_us,
   output logic                                  req_full,
   input  wire logic [irfd_pkg::INTERVAL_W-1:0]  leader_thresh,
   input  wire logic [irfd_pkg::INTERVAL_W-1:0]  one_thresh,
   output logic                                  class_push,
   output irfd_pkg::edge_class_type              class_word,
   input  wire logic                             class_full
);
   import irfd_pkg::*;

   localparam int EDGE_CNT_W = $clog2(EDGES_PER_FRAME);
   localparam logic [EDGE_CNT_W-1:0] LAST_EDGE = EDGE_CNT_W'(EDGES_PER_FRAME - 1);

   logic [EDGE_CNT_W-1:0] edge_count_ff, edge_count_in;
   logic                  accept;
   logic                  is_last;

   assign req_full   = class_full;
   assign accept     = req_push && !class_full;
   assign class_push = accept;
   assign is_last    = (edge_count_ff == LAST_EDGE);

   assign class_word.above_leader = (req_interval_us > leader_thresh);
   assign class_word.above_one    = (req_interval_us > one_thresh);
   assign class_word.frame_last   = is_last;

   always_comb begin
      edge_count_in = edge_count_ff;
      if (accept) begin
         edge_count_in = is_last ? '0 : edge_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
      end else begin
         edge_count_ff <= edge_count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/irfd_back.sv
// Back end: tracks leader and data bits of the frame and builds its result word.
`default_nettype none
module irfd_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             class_valid,
   input  wire irfd_pkg::edge_class_type         class_word,
   output logic                                  class_pop,
   input  wire logic [irfd_pkg::ADDR_W-1:0]      device_address,
   output logic                                  result_push,
   output irfd_pkg::frame_result_type            result_word,
   input  wire logic                             result_full
);
   import irfd_pkg::*;

   localparam logic [BIT_CNT_W-1:0] BITS_DONE = BIT_CNT_W'(FRAME_BITS);

   logic                   leader_seen_ff, leader_seen_in;
   logic [BIT_CNT_W-1:0]   bits_ff, bits_in;
   logic [FRAME_BITS-1:0]  shift_ff, shift_in;
   logic                   take;
   logic                   leader_next;
   logic [BIT_CNT_W-1:0]   bits_next;
   logic [FRAME_BITS-1:0]  shift_next;
   logic [ADDR_W-1:0]      addr_next;

   assign take        = class_valid && !result_full;
   assign class_pop   = take;
   assign result_push = take && class_word.frame_last;

   always_comb begin
      leader_next = leader_seen_ff;
      bits_next   = bits_ff;
      shift_next  = shift_ff;
      if (leader_seen_ff) begin
         if (bits_ff < BITS_DONE) begin
            shift_next = {shift_ff[FRAME_BITS-2:0], class_word.above_one};
            bits_next  = bits_ff + 1'b1;
         end
      end else if (class_word.above_leader) begin
         leader_next = 1'b1;
      end
      addr_next = shift_next[FRAME_BITS-1 -: ADDR_W];
   end

   always_comb begin
      result_word.address_code = '0;
      result_word.command_code = '0;
      if (!leader_next) begin
         result_word.frame_status = STATUS_NO_LEADER;
      end else if (bits_next < BITS_DONE) begin
         result_word.frame_status = STATUS_FEW_BITS;
      end else begin
         result_word.address_code = addr_next;
         result_word.command_code = shift_next[CMD_W-1:0];
         result_word.frame_status = (addr_next == device_address) ? STATUS_OK
                                                                  : STATUS_ADDR_MISS;
      end
   end

   always_comb begin
      leader_seen_in = leader_seen_ff;
      bits_in        = bits_ff;
      shift_in       = shift_ff;
      if (take) begin
         if (class_word.frame_last) begin
            leader_seen_in = 1'b0;
            bits_in        = '0;
            shift_in       = '0;
         end else begin
            leader_seen_in = leader_next;
            bits_in        = bits_next;
            shift_in       = shift_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_seen_ff <= 1'b0;
         bits_ff        <= '0;
         shift_ff       <= '0;
      end else begin
         leader_seen_ff <= leader_seen_in;
         bits_ff        <= bits_in;
         shift_ff       <= shift_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (bits_ff != '0) |-> leader_seen_ff)
      else $error("data bits counted without a leader");

   assert property (@(posedge clock) disable iff (reset) bits_ff <= BITS_DONE)
      else $error("more data bits than a frame holds");

   assert property (@(posedge clock) disable iff (reset)
      result_push |=> (!leader_seen_ff && bits_ff == '0))
      else $error("frame state not cleared after result");

endmodule
`default_nettype wire

### rtl/core/ir_remote_frame_decoder.sv
// Top level of the IR remote frame decoder.
//
// Input: one word per rising IR edge, req_interval_us = microseconds since the
// previous rising edge. A word is taken at a clock edge with req_push high and
// req_full low. Every EDGES_PER_FRAME words form one frame.
// Output: one word per frame, on the frame's last edge: rsp_frame_status
// (ok, no leader, too few bits, address mismatch), rsp_address_code and
// rsp_command_code. The oldest word shows while rsp_empty is low and leaves on
// rsp_pop. Configuration: csr_write_enable writes csr_write_data into register
// csr_index (device address, leader threshold, one threshold); write only when idle.
// Throughput: one edge word per cycle while req_full is low. A frame's last edge
// word is registered in the classified-edge queue; the back end then pushes the
// frame's result word into the result queue, from which it shows on the rsp ports.
// Reset clears frame state and both queues, and loads the register defaults.
// When the receiver stalls, the result queue fills, the back end stops taking
// classified edges, the edge queue fills and req_full rises; nothing is dropped.
`default_nettype none
module ir_remote_frame_decoder #(
   parameter int EDGES_PER_FRAME = irfd_pkg::EDGES_PER_FRAME
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   input  wire logic [irfd_pkg::INTERVAL_W-1:0]   req_interval_us,
   output logic                                   req_full,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [irfd_pkg::STATUS_W-1:0]          rsp_frame_status,
   output logic [irfd_pkg::ADDR_W-1:0]            rsp_address_code,
   output logic [irfd_pkg::CMD_W-1:0]             rsp_command_code,
   input  wire logic                              csr_write_enable,
   input  wire logic [irfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [irfd_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import irfd_pkg::*;

   localparam int CLASS_W  = $bits(edge_class_type);
   localparam int RESULT_W = $bits(frame_result_type);

   logic [ADDR_W-1:0]     device_address_ff;
   logic [INTERVAL_W-1:0] leader_thresh_ff;
   logic [INTERVAL_W-1:0] one_thresh_ff;

   edge_class_type        front_word;
   edge_class_type        back_word;
   logic [CLASS_W-1:0]    back_bits;
   logic                  front_push;
   logic                  class_full;
   logic                  class_empty;
   logic                  class_pop;

   frame_result_type      result_in_word;
   frame_result_type      result_out_word;
   logic [RESULT_W-1:0]   result_out_bits;
   logic                  result_push;
   logic                  result_full;

   // Configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         leader_thresh_ff  <= LEADER_THRESH_RESET;
         one_thresh_ff     <= ONE_THRESH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr_write_data[ADDR_W-1:0];
            CSR_LEADER_THRESH:  leader_thresh_ff  <= csr_write_data[INTERVAL_W-1:0];
            CSR_ONE_THRESH:     one_thresh_ff     <= csr_write_data[INTERVAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Classify each edge as it arrives
   irfd_front #(
      .EDGES_PER_FRAME(EDGES_PER_FRAME)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_interval_us (req_interval_us),
      .req_full        (req_full),
      .leader_thresh   (leader_thresh_ff),
      .one_thresh      (one_thresh_ff),
      .class_push      (front_push),
      .class_word      (front_word),
      .class_full      (class_full)
   );

   // Decouple front and back
   irfd_queue #(
      .WIDTH(CLASS_W),
      .DEPTH(CLASS_DEPTH)
   ) u_class_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_word),
      .full      (class_full),
      .pop       (class_pop),
      .pop_data  (back_bits),
      .empty     (class_empty)
   );

   assign back_word = back_bits;

   // Assemble frames and decide status
   irfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .class_valid    (!class_empty),
      .class_word     (back_word),
      .class_pop      (class_pop),
      .device_address (device_address_ff),
      .result_push    (result_push),
      .result_word    (result_in_word),
      .result_full    (result_full)
   );

   // Hold finished frames for the receiver
   irfd_queue #(
      .WIDTH(RESULT_W),
      .DEPTH(RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_in_word),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_out_bits),
      .empty     (rsp_empty)
   );

   assign result_out_word  = result_out_bits;
   assign rsp_frame_status = result_out_word.frame_status;
   assign rsp_address_code = result_out_word.address_code;
   assign rsp_command_code = result_out_word.command_code;

endmodule
`default_nettype wire

### tb/ir_remote_frame_decoder_tb.sv
// Self-checking testbench of the IR remote frame decoder: directed and random frames.
`default_nettype none
module ir_remote_frame_decoder_tb;
   import irfd_pkg::*;

   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 18'd209715;
   localparam logic [5:0] NO_LEADER_AT     = 6'd63;   // row marker: frame has no leader
   localparam int LATE_LEADER_AT   = EDGES_PER_FRAME - FRAME_BITS;  // first leader slot short of bits
   localparam int RANDOM_PHASES    = 6;
   localparam int FRAMES_PER_PHASE = 3;
   localparam int PRESSURE_PHASE   = 4;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int SETTLE_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT   = 3000;

   typedef enum {FRAME_CLEAN, FRAME_NO_LEADER, FRAME_LATE_LEADER, FRAME_NOISE} frame_kind_type;
   typedef enum {POP_ALWAYS, POP_COIN, POP_EVERY_FOURTH, POP_RARE} pop_pattern_type;

   // One directed frame: gap values by position relative to the leader burst
   typedef struct packed {
      logic [5:0]            lead_at;
      logic [INTERVAL_W-1:0] pre_us, lead_us, zero_us, one_us, post_us;
      logic [FRAME_BITS-1:0] data;
      logic                  typed;
      frame_result_type      want;
   } frame_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic [INTERVAL_W-1:0]  req_interval_us = '0;
   logic                   req_full;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [STATUS_W-1:0]    rsp_frame_status;
   logic [ADDR_W-1:0]      rsp_address_code;
   logic [CMD_W-1:0]       rsp_command_code;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Decoder shadow: configuration and frame state
   logic [ADDR_W-1:0]     dev_addr;
   logic [INTERVAL_W-1:0] lead_thr;
   logic [INTERVAL_W-1:0] one_thr;
   logic [5:0]            edge_cnt;
   logic                  lead_found;
   logic [BIT_CNT_W-1:0]  bit_cnt;
   logic [FRAME_BITS-1:0] shift_reg;

   frame_result_type      expected_frames[$];
   frame_row_type         directed_rows[$];
   logic [INTERVAL_W-1:0] frame_gaps[EDGES_PER_FRAME];

   int error_count    = 0;
   int words_sent     = 0;
   int frames_sent    = 0;
   int frames_checked = 0;
   int full_cycles    = 0;
   int quiet_cycles   = 0;
   int burst_left     = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   bit hold_off_req   = 1'b0;

   ir_remote_frame_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_interval_us  (req_interval_us),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_frame_status (rsp_frame_status),
      .rsp_address_code (rsp_address_code),
      .rsp_command_code (rsp_command_code),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_frame_state();
      edge_cnt   = '0;
      lead_found = 1'b0;
      bit_cnt    = '0;
      shift_reg  = '0;
   endfunction

   // Advance the frame state by one edge word; flag a finished frame.
   task automatic decode_edge(input logic [INTERVAL_W-1:0] gap_us, output bit frame_done,
                              output frame_result_type res);
      res        = '0;
      frame_done = 1'b0;
      // Once the leader is in, long gaps are data ones, never a new leader
      if (lead_found) begin
         if (bit_cnt < FRAME_BITS) begin
            shift_reg = {shift_reg[FRAME_BITS-2:0], gap_us > one_thr};
            bit_cnt   = bit_cnt + 1'b1;
         end
      end else if (gap_us > lead_thr) begin
         lead_found = 1'b1;
      end
      edge_cnt = edge_cnt + 1'b1;
      if (edge_cnt == EDGES_PER_FRAME) begin
         frame_done = 1'b1;
         if (!lead_found) begin
            res.frame_status = STATUS_NO_LEADER;
         end else if (bit_cnt < FRAME_BITS) begin
            res.frame_status = STATUS_FEW_BITS;
         end else begin
            // Mismatching address still reports the decoded codes
            res.address_code = shift_reg[FRAME_BITS-1:CMD_W];
            res.command_code = shift_reg[CMD_W-1:0];
            res.frame_status = (shift_reg[FRAME_BITS-1:CMD_W] == dev_addr) ?
                               STATUS_OK : STATUS_ADDR_MISS;
         end
         clear_frame_state();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic frame_row_type frame_row(input int lead_at, input int pre_us,
                                               input int lead_us, input int zero_us,
                                               input int one_us, input int post_us,
                                               input logic [FRAME_BITS-1:0] data,
                                               input bit typed,
                                               input logic [STATUS_W-1:0] status,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [CMD_W-1:0] cmd);
      frame_row_type r;
      r.lead_at = 6'(lead_at);
      r.pre_us  = INTERVAL_W'(pre_us);
      r.lead_us = INTERVAL_W'(lead_us);
      r.zero_us = INTERVAL_W'(zero_us);
      r.one_us  = INTERVAL_W'(one_us);
      r.post_us = INTERVAL_W'(post_us);
      r.data    = data;
      r.typed   = typed;
      r.want    = '{frame_status: status, address_code: addr, command_code: cmd};
      return r;
   endfunction

   // Directed frames, all under the reset configuration (address 0, 8000 / 1700 us).
   // Typed results are the obvious ones; the rest go through the predictor.
   function automatic void load_directed_rows();
      // no leader: all zero gaps, then all gaps exactly at the leader threshold
      directed_rows.push_back(frame_row(NO_LEADER_AT, 0, 0, 0, 0, 0, 32'h0,
                                        1, STATUS_NO_LEADER, 16'h0, 16'h0));
      directed_rows.push_back(frame_row(NO_LEADER_AT, 8000, 0, 0, 0, 0, 32'h0,
                                        1, STATUS_NO_LEADER, 16'h0, 16'h0));
      // leader one above threshold, ones one above the bit threshold
      directed_rows.push_back(frame_row(0, 0, 8001, 0, 1701, 0, 32'h0000_1234,
                                        1, STATUS_OK, 16'h0000, 16'h1234));
      // longest gaps everywhere: ones after the leader, then ignored tail
      directed_rows.push_back(frame_row(0, 0, INTERVAL_MAX, 1700, INTERVAL_MAX, INTERVAL_MAX,
                                        32'hFFFF_FFFF, 1, STATUS_ADDR_MISS, 16'hFFFF, 16'hFFFF));
      // zeros exactly at the bit threshold
      directed_rows.push_back(frame_row(0, 0, 8001, 1700, 1701, 0, 32'h0000_0000,
                                        1, STATUS_OK, 16'h0000, 16'h0000));
      // leader on the frame's last edge
      directed_rows.push_back(frame_row(EDGES_PER_FRAME - 1, 0, 8001, 0, 0, 0, 32'h0,
                                        1, STATUS_FEW_BITS, 16'h0, 16'h0));
      // leader one slot too late: a bit short
      directed_rows.push_back(frame_row(LATE_LEADER_AT, 7999, 8001, 0, INTERVAL_MAX, 0,
                                        32'hDEAD_BEEF, 1, STATUS_FEW_BITS, 16'h0, 16'h0));
      // latest leader that still fills all bits
      directed_rows.push_back(frame_row(LATE_LEADER_AT - 1, 8000, 9000, 0, 1701, 0,
                                        32'h0000_A5C3, 1, STATUS_OK, 16'h0000, 16'hA5C3));
      directed_rows.push_back(frame_row(LATE_LEADER_AT - 1, 8000, 9000, 0, 1701, 0,
                                        32'h8001_7FFE, 1, STATUS_ADDR_MISS, 16'h8001, 16'h7FFE));
      // typical remote timing
      directed_rows.push_back(frame_row(0, 0, 13500, 1120, 2250, 40000, 32'h00FF_30CF,
                                        0, STATUS_OK, 16'h0, 16'h0));
      directed_rows.push_back(frame_row(3, 8000, 9000, 560, 1690, 0, 32'h5A5A_C3C3,
                                        0, STATUS_OK, 16'h0, 16'h0));
      directed_rows.push_back(frame_row(10, 4500, 13500, 1125, 2250, 96000, 32'h0000_FF00,
                                        0, STATUS_OK, 16'h0, 16'h0));
   endfunction

   function automatic void build_row_frame(input frame_row_type r);
      int k;
      for (int e = 0; e < EDGES_PER_FRAME; e++) begin
         k = e - int'(r.lead_at) - 1;
         if (r.lead_at == NO_LEADER_AT || e < r.lead_at) begin
            frame_gaps[e] = r.pre_us;
         end else if (e == r.lead_at) begin
            frame_gaps[e] = r.lead_us;
         end else if (k < FRAME_BITS) begin
            frame_gaps[e] = r.data[FRAME_BITS-1-k] ? r.one_us : r.zero_us;
         end else begin
            frame_gaps[e] = r.post_us;
         end
      end
   endfunction

   function automatic logic [INTERVAL_W-1:0] gap_above(input logic [INTERVAL_W-1:0] limit);
      return (limit < INTERVAL_MAX) ? INTERVAL_W'($urandom_range(INTERVAL_MAX, limit + 1)) :
                                      INTERVAL_MAX;
   endfunction

   // Mostly clean frames with random content; some without leader, late leader or noise
   function automatic void build_random_frame();
      frame_kind_type        kind;
      int                    r;
      int                    lead_at;
      int                    k;
      logic [ADDR_W-1:0]     addr;
      logic [CMD_W-1:0]      cmd;
      logic [FRAME_BITS-1:0] data;
      r = $urandom_range(9, 0);
      kind = (r < 7) ? FRAME_CLEAN : (r == 7) ? FRAME_NO_LEADER :
             (r == 8) ? FRAME_LATE_LEADER : FRAME_NOISE;
      lead_at = (kind == FRAME_LATE_LEADER) ?
                $urandom_range(EDGES_PER_FRAME - 1, LATE_LEADER_AT) :
                $urandom_range(LATE_LEADER_AT - 1, 0);
      addr = $urandom_range(1, 0) ? dev_addr : ADDR_W'($urandom);
      cmd  = CMD_W'($urandom);
      data = {addr, cmd};
      for (int e = 0; e < EDGES_PER_FRAME; e++) begin
         k = e - lead_at - 1;
         if (kind == FRAME_NOISE) begin
            frame_gaps[e] = INTERVAL_W'($urandom_range(INTERVAL_MAX, 0));
         end else if (kind == FRAME_NO_LEADER || e < lead_at) begin
            frame_gaps[e] = INTERVAL_W'($urandom_range(lead_thr, 0));
         end else if (e == lead_at) begin
            frame_gaps[e] = gap_above(lead_thr);
         end else if (k < FRAME_BITS) begin
            frame_gaps[e] = data[FRAME_BITS-1-k] ? gap_above(one_thr) :
                            INTERVAL_W'($urandom_range(one_thr, 0));
         end else begin
            frame_gaps[e] = INTERVAL_W'($urandom_range(INTERVAL_MAX, 0));
         end
      end
   endfunction

   // Offer one edge word in bursts with random gaps; predict on acceptance.
   task automatic send_edge(input logic [INTERVAL_W-1:0] gap_us, input bit typed,
                            input frame_result_type typed_res);
      bit               frame_done;
      frame_result_type res;
      int               idle;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(300, 100) :
                      $urandom_range(20, 1);
         // no gaps while the receiver holds off, so the block backs up
         if (!hold_off_req) begin
            idle = $urandom_range(12, 1);
            req_push <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
      burst_left--;
      req_push        <= 1'b1;
      req_interval_us <= gap_us;
      do @(posedge clock); while (req_full);
      words_sent++;
      decode_edge(gap_us, frame_done, res);
      if (frame_done) begin
         expected_frames.push_back(typed ? typed_res : res);
      end
   endtask

   task automatic send_frame(input bit typed, input frame_result_type typed_res);
      for (int e = 0; e < EDGES_PER_FRAME; e++) begin
         send_edge(frame_gaps[e], typed, typed_res);
      end
      frames_sent++;
   endtask

   // Drop push and wait until every expected word is out and the block is quiet.
   task automatic drain_results();
      req_push <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CSR_DEVICE_ADDRESS: dev_addr = value[ADDR_W-1:0];
         CSR_LEADER_THRESH:  lead_thr = value;
         CSR_ONE_THRESH:     one_thr  = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] dev_word,
                             input logic [INTERVAL_W-1:0] leader_us,
                             input logic [INTERVAL_W-1:0] one_us);
      write_csr(CSR_DEVICE_ADDRESS, dev_word);
      write_csr(CSR_LEADER_THRESH, leader_us);
      write_csr(CSR_ONE_THRESH, one_us);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Compare every popped word with the oldest expectation; watch for a hang.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset) begin
         if (req_push && req_full) full_cycles++;
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_pop && !rsp_empty) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual status %0d",
                        $time, rsp_frame_status);
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_status", 32'(want.frame_status), 32'(rsp_frame_status));
               check_field("address_code", 32'(want.address_code), 32'(rsp_address_code));
               check_field("command_code", 32'(want.command_code), 32'(rsp_command_code));
               status_seen[want.frame_status]++;
               frames_checked++;
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_frames.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Receiver: switch between pop patterns; hold off for a long stretch on request.
   initial begin
      pop_pattern_type pattern;
      int              pattern_left;
      int              tick;
      bit              pop_now;
      pattern      = POP_ALWAYS;
      pattern_left = 0;
      tick         = 0;
      @(negedge reset);
      forever begin
         if (hold_off_req) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern      = pop_pattern_type'($urandom_range(3, 0));
               pattern_left = $urandom_range(200, 20);
               tick         = 0;
            end
            case (pattern)
               POP_ALWAYS:       pop_now = 1'b1;
               POP_COIN:         pop_now = 1'($urandom_range(1, 0));
               POP_EVERY_FOURTH: pop_now = (tick % 4) == 3;
               default:          pop_now = ($urandom_range(9, 0) == 0);
            endcase
            pattern_left--;
            tick++;
            rsp_pop <= pop_now;
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      logic [CSR_DATA_W-1:0] dev_word;
      dev_addr = DEVICE_ADDRESS_RESET;
      lead_thr = LEADER_THRESH_RESET;
      one_thr  = ONE_THRESH_RESET;
      clear_frame_state();
      load_directed_rows();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames run on the reset register values
      foreach (directed_rows[i]) begin
         build_row_frame(directed_rows[i]);
         send_frame(directed_rows[i].typed, directed_rows[i].want);
      end

      // Random frames across settings: reset thresholds first, then extremes, back-pressure and random values
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         dev_word = CSR_DATA_W'($urandom);
         case (p)
            0:       set_config(dev_word, LEADER_THRESH_RESET, ONE_THRESH_RESET);
            1:       set_config('1, '0, '0);
            2:       set_config('0, INTERVAL_MAX, INTERVAL_MAX);
            3:       set_config(dev_word, '0, INTERVAL_MAX);
            PRESSURE_PHASE: set_config(dev_word, LEADER_THRESH_RESET, ONE_THRESH_RESET);
            default: set_config(dev_word, INTERVAL_W'($urandom_range(INTERVAL_MAX, 0)),
                                INTERVAL_W'($urandom_range(INTERVAL_MAX, 0)));
         endcase
         if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
         for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
            build_random_frame();
            send_frame(1'b0, '0);
         end
      end
      drain_results();

      $display("run: %0d edge words in %0d frames, %0d results checked, input stalled %0d cycles",
               words_sent, frames_sent, frames_checked, full_cycles);
      $display("status mix: ok %0d, no leader %0d, few bits %0d, address miss %0d",
               status_seen[STATUS_OK], status_seen[STATUS_NO_LEADER],
               status_seen[STATUS_FEW_BITS], status_seen[STATUS_ADDR_MISS]);
      if (error_count == 0 && rsp_empty) begin
         $display("simulation ok");
      end else begin
         if (!rsp_empty) $display("%0t: result word left over with none expected", $time);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

### ir_remote_frame_decoder.f
rtl/core/irfd_pkg.sv
rtl/core/irfd_queue.sv
rtl/core/irfd_front.sv
rtl/core/irfd_back.sv
rtl/core/ir_remote_frame_decoder.sv
tb/ir_remote_frame_decoder_tb.sv
